>>> hdl/mmkv_pkg.sv
package mmkv_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT,
    ST_FLUSH
  } state_t;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  // request and result field widths on the stream ports
  localparam int FUNC_BITS   = 2;
  localparam int KEY_FIELD   = 32;
  localparam int VALUE_FIELD = 32;
  localparam int COUNT_FIELD = 7;

endpackage

>>> hdl/mmkv_pair_ram.sv
module mmkv_pair_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/multimap_key_value_store.sv
// add and unused codes give their result from the start state, without a scan
// remove and search scan one stored pair per cycle, a search stalling while a held match waits on the output
// (remove scans up to the match, then moves each later pair down by one)
// throughput: one request at a time; the next request is taken once the sequencer is idle
// reset: rst is synchronous, empties the store; pair memory is not cleared
module multimap_key_value_store
  import mmkv_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[1:0], key_in[33:2], value_in[65:34], zero pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[1:0], value_out[33:2], pair_count[40:34],
                                     // is_empty[41], zero pad
  output logic        m_axis_tlast
);

  // stored key and value widths, the request fields are only 32 bits wide
  localparam int KW = (KEY_BITS < KEY_FIELD) ? KEY_BITS : KEY_FIELD;
  localparam int VW = (VALUE_BITS < VALUE_FIELD) ? VALUE_BITS : VALUE_FIELD;
  localparam int DW = KW + VW;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam int KEY_LSB   = FUNC_BITS;
  localparam int VALUE_LSB = FUNC_BITS + KEY_FIELD;

  // sequencer and request registers
  state_t         state, state_next;
  logic [1:0]     req_op;
  logic [KW-1:0]  req_key;
  logic [VW-1:0]  req_val;
  logic [CW-1:0]  count, count_next;
  logic [IW-1:0]  idx, idx_next;

  // search keeps one match back so the final one can carry tlast
  logic           pend_valid, pend_valid_next;
  logic [VW-1:0]  pend_value, pend_value_next;

  // memory ports
  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic [DW-1:0]  wr_data, rd_data;

  // output register and its load controls
  logic           out_valid;
  logic [1:0]     out_status;
  logic [31:0]    out_value;
  logic           out_last;
  logic [6:0]     out_count;
  logic           out_empty;
  logic           load;
  logic [1:0]     ld_status;
  logic [VW-1:0]  ld_value;
  logic           ld_last;

  logic           out_free;
  logic           key_hit, pair_hit, at_last, shift_done;
  logic [KW-1:0]  rd_key;
  logic [VW-1:0]  rd_val;

  mmkv_pair_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  // pair word: key in the low bits, value above
  assign rd_key     = rd_data[KW-1:0];
  assign rd_val     = rd_data[DW-1:KW];
  assign key_hit    = (rd_key == req_key);
  assign pair_hit   = key_hit && (rd_val == req_val);
  assign at_last    = (CW'(idx) == count - CW'(1));
  assign shift_done = (CW'(idx) + CW'(1) == count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pend_value <= pend_value_next;
    if (s_axis_tvalid && s_axis_tready) begin
      req_op  <= s_axis_tdata[FUNC_BITS-1:0];
      req_key <= s_axis_tdata[KEY_LSB +: KW];
      req_val <= s_axis_tdata[VALUE_LSB +: VW];
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_value_next = pend_value;
    rd_en           = 1'b0;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = {req_val, req_key};
    load            = 1'b0;
    ld_status       = STAT_DONE;
    ld_value        = '0;
    ld_last         = 1'b1;

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_START;
        end
      end

      ST_START: begin
        case (req_op)
          OP_ADD: begin
            if (out_free) begin
              load = 1'b1;
              if (count == CW'(ENTRIES)) begin
                ld_status = STAT_FULL;
              end else begin
                // append at the end of the list
                wr_en      = 1'b1;
                wr_addr    = count[IW-1:0];
                count_next = count + CW'(1);
              end
              state_next = ST_IDLE;
            end
          end
          OP_REMOVE, OP_SEARCH: begin
            pend_valid_next = 1'b0;
            pend_value_next = '0;
            if (count == '0) begin
              state_next = ST_FLUSH;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              idx_next   = '0;
              state_next = ST_SCAN;
            end
          end
          default: begin
            // unused code: plain done result, store untouched
            if (out_free) begin
              load       = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        if (req_op == OP_REMOVE) begin
          if (pair_hit) begin
            pend_valid_next = 1'b1;
            if (at_last) begin
              count_next = count - CW'(1);
              state_next = ST_FLUSH;
            end else begin
              // fetch the next pair, it moves into this slot
              rd_en      = 1'b1;
              rd_addr    = idx + IW'(1);
              state_next = ST_SHIFT;
            end
          end else if (at_last) begin
            state_next = ST_FLUSH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx + IW'(1);
            idx_next = idx + IW'(1);
          end
        end else if (!(key_hit && pend_valid && !out_free)) begin
          // search: a new match releases the one held back
          if (key_hit) begin
            pend_valid_next = 1'b1;
            pend_value_next = rd_val;
            if (pend_valid) begin
              load     = 1'b1;
              ld_value = pend_value;
              ld_last  = 1'b0;
            end
          end
          if (at_last) begin
            state_next = ST_FLUSH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx + IW'(1);
            idx_next = idx + IW'(1);
          end
        end
      end

      ST_SHIFT: begin
        // rd_data holds pair idx+1, move it down to idx
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (shift_done) begin
          count_next = count - CW'(1);
          state_next = ST_FLUSH;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + IW'(2);
          idx_next = idx + IW'(1);
        end
      end

      ST_FLUSH: begin
        // final result of remove or search
        if (out_free) begin
          load       = 1'b1;
          ld_status  = pend_valid ? STAT_DONE : STAT_NOT_FOUND;
          ld_value   = pend_value;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register, refilled as soon as the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_value  <= 32'(ld_value);
      out_last   <= ld_last;
      out_count  <= COUNT_FIELD'(count_next);
      out_empty  <= (count_next == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {6'b0, out_empty, out_count, out_value, out_status};

endmodule

>>> test/multimap_key_value_store_tb.sv
package mmkv_tb_pkg;
  import mmkv_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
    logic [6:0]  count;
    logic        empty;
  } pair_result_t;

  // shadow copy of the pair store plus the results still owed by the block
  class multimap_predictor;
    logic [31:0] keys [STORE_DEPTH];
    logic [31:0] vals [STORE_DEPTH];
    int unsigned held;
    pair_result_t owed_results[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned results;
    int unsigned full_rejects;
    int unsigned widest_search;

    function new();
      held = 0;
      errors = 0;
      requests = 0;
      results = 0;
      full_rejects = 0;
      widest_search = 0;
    endfunction

    function void owe(logic [1:0] status, logic [31:0] value, logic last);
      pair_result_t r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      r.count  = 7'(held);
      r.empty  = (held == 0);
      owed_results.insert(owed_results.size(), r);
    endfunction

    function void take_request(logic [1:0] func, logic [31:0] key, logic [31:0] value);
      int unsigned i;
      int unsigned j;
      int unsigned hits;
      int unsigned seen;
      bit found;
      requests++;
      case (func)
        OP_ADD: begin
          if (held >= STORE_DEPTH) begin
            full_rejects++;
            owe(STAT_FULL, '0, 1'b1);
          end else begin
            keys[held] = key;
            vals[held] = value;
            held++;
            owe(STAT_DONE, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          found = 1'b0;
          for (i = 0; i < held && !found; i++) begin
            if (keys[i] == key && vals[i] == value) begin
              found = 1'b1;
              for (j = i; j + 1 < held; j++) begin
                keys[j] = keys[j + 1];
                vals[j] = vals[j + 1];
              end
            end
          end
          if (found) held--;
          owe(found ? STAT_DONE : STAT_NOT_FOUND, '0, 1'b1);
        end
        OP_SEARCH: begin
          hits = 0;
          for (i = 0; i < held; i++)
            if (keys[i] == key) hits++;
          if (hits > widest_search) widest_search = hits;
          if (hits == 0) begin
            owe(STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            seen = 0;
            for (i = 0; i < held; i++) begin
              if (keys[i] == key) begin
                seen++;
                owe(STAT_DONE, vals[i], seen == hits);
              end
            end
          end
        end
        default: owe(STAT_DONE, '0, 1'b1);
      endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] value, logic last,
                               logic [6:0] count, logic empty);
      pair_result_t want;
      results++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d value=%h last=%0d count=%0d empty=%0d",
                 $time, status, value, last, count, empty);
        return;
      end
      want = owed_results.pop_front();
      compare("status", 32'(want.status), 32'(status));
      compare("value_out", want.value, value);
      compare("last", 32'(want.last), 32'(last));
      compare("pair_count", 32'(want.count), 32'(count));
      compare("is_empty", 32'(want.empty), 32'(empty));
    endfunction
  endclass
endpackage

module multimap_key_value_store_tb;
  import mmkv_pkg::*;
  import mmkv_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 200;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // func[1:0], key_in[33:2], value_in[65:34], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // status[1:0], value_out[33:2], pair_count[40:34],
                                    // is_empty[41], zero pad
  logic        m_axis_tlast;

  multimap_key_value_store dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  multimap_predictor pred = new();

  // idle rates in percent, changed per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold: stimulus flips the toggle, receiver counts the cycles
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  int quiet_cycles = 0;

  // small pools so that keys repeat and removes find their pairs
  logic [31:0] key_pool [8];
  logic [31:0] value_pool [6];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random backpressure, or a solid hold when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every accepted result is matched against the oldest owed one
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      pred.check_result(m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tlast,
                        m_axis_tdata[40:34], m_axis_tdata[41]);
  end

  // watchdog: a stretch with no handshake on either side that outlasts WATCHDOG_LIMIT is a hang
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still owed",
               $time, quiet_cycles, pred.owed_results.size());
      $display("multimap_key_value_store_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  // offer one request, idling at random first, and log it once taken
  task automatic send_request(input logic [1:0] func, input logic [31:0] key,
                              input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, value, key, func};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred.take_request(func, key, value);
  endtask

  // random request; removes and searches mostly aim at stored pairs
  task automatic send_random(input int add_pct);
    int r;
    int unsigned idx;
    logic [31:0] key;
    logic [31:0] value;
    r     = $urandom_range(99);
    key   = pick_key();
    value = pick_value();
    if (r < 4) begin
      send_request(OP_UNUSED, key, value);
    end else if (r < 4 + add_pct) begin
      send_request(OP_ADD, key, value);
    end else if (r < 4 + add_pct + (96 - add_pct) / 2) begin
      if (pred.held > 0 && $urandom_range(99) < 65) begin
        idx   = $urandom_range(pred.held - 1);
        key   = pred.keys[idx];
        value = pred.vals[idx];
      end
      send_request(OP_REMOVE, key, value);
    end else begin
      if (pred.held > 0 && $urandom_range(99) < 70)
        key = pred.keys[$urandom_range(pred.held - 1)];
      send_request(OP_SEARCH, key, value);
    end
  endtask

  // sender pause until the block has delivered everything owed
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pred.owed_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] fill_key;
    int unsigned idx;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h5555_5555;
    key_pool[3] = 32'hAAAA_AAAA;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) value_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 9;
    recv_idle_pct = 83;

    // directed: empty store, extremes, duplicates, gap closing, misses
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);  // search on empty
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);  // remove on empty
    send_request(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);  // unused code, empty
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_0000);
    send_request(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_0000);  // same pair twice
    send_request(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);  // three values, in order
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_SEARCH, 32'h1234_5678, 32'h0000_0000);  // no such key
    send_request(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);  // middle pair, gap closes
    send_request(OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);  // value_in ignored
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);  // first of the duplicates
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0012);  // key hits, value misses
    send_request(OP_REMOVE, 32'h0000_0005, 32'h0000_0000);  // value hits, key misses
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused code, store held
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);  // back to empty
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    repeat (70) send_random(50);
    wait_drained();

    // sender mostly idle, receiver mostly ready
    // empty the store, fill it with one key, then push past full
    send_idle_pct = 83;
    recv_idle_pct = 9;
    while (pred.held > 0) begin
      idx = $urandom_range(pred.held - 1);
      send_request(OP_REMOVE, pred.keys[idx], pred.vals[idx]);
    end
    fill_key = pick_key();
    repeat (STORE_DEPTH) send_request(OP_ADD, fill_key, pick_value());
    send_request(OP_ADD, pick_key(), pick_value());          // store full
    send_request(OP_ADD, fill_key, pick_value());            // still full
    send_request(OP_SEARCH, fill_key, 32'h0000_0000);        // every entry matches
    send_request(OP_SEARCH, ~fill_key, 32'h0000_0000);
    repeat (20) send_random(25);
    wait_drained();

    // no idling; a long receiver hold while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (20) send_random(50);
    hold_toggle = ~hold_toggle;
    repeat (50) send_random(50);
    wait_drained();

    // let any late or spurious result show up
    repeat (STORE_DEPTH + 16) @(posedge clk);

    $display("covered %0d requests, %0d results, widest search %0d values, %0d adds on full",
             pred.requests, pred.results, pred.widest_search, pred.full_rejects);
    $display("idle mixes 9/83, 83/9 and none, plus a %0d-cycle result hold", HOLD_CYCLES);
    if (pred.errors == 0)
      $display("multimap_key_value_store_tb: PASS");
    else
      $display("multimap_key_value_store_tb: FAIL");
    $finish;
  end
endmodule
